// ===== rtl/load_cell_adc_reader_defines.svh =====
// Assertion macros shared by the load cell reader RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef LOAD_CELL_ADC_READER_DEFINES_SVH
`define LOAD_CELL_ADC_READER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define LCAR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lcar assertion failed");

// Next-cycle implication, checked out of reset
`define LCAR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lcar assertion failed");

`endif

// ===== rtl/lcar_pkg.sv =====
// Package for the load cell reader: widths, codes, controller and datapath types.
// No dependencies.
`timescale 1ns / 1ps
package lcar_pkg;

    localparam int DATA_BITS  = 24;
    localparam int COUNT_BITS = 8;
    localparam int ACC_W      = DATA_BITS + COUNT_BITS;
    localparam int FRAC_SHIFT = 16;
    localparam int DIVD_W     = DATA_BITS + 1 + FRAC_SHIFT;
    localparam int DIVS_W     = 32;
    localparam int UNITS_W    = 42;
    localparam int DCNT_W     = $clog2(DIVD_W + 1);

    localparam logic [1:0] FN_READ = 2'd0;
    localparam logic [1:0] FN_TARE = 2'd1;
    localparam logic [1:0] FN_LOAD = 2'd2;
    localparam logic [1:0] FN_NONE = 2'd3;

    localparam logic [2:0] CFG_GAIN    = 3'd0;
    localparam logic [2:0] CFG_SCALE   = 3'd1;
    localparam logic [2:0] CFG_HALF    = 3'd2;
    localparam logic [2:0] CFG_TIMEOUT = 3'd3;
    localparam logic [2:0] CFG_PDOWN   = 3'd4;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_TIMEOUT    = 2'd1,
        STAT_ZERO_SCALE = 2'd2,
        STAT_POWER_DOWN = 2'd3
    } stat_t;

    typedef enum logic [1:0] {
        PIN_IDLE,
        PIN_WAIT,
        PIN_HIGH,
        PIN_LOW
    } pin_t;

    typedef enum logic [2:0] {
        C_TICK,
        C_AVG_GO,
        C_AVG,
        C_POST,
        C_UNITS
    } ctrl_t;

    typedef struct packed {
        logic  start;
        logic  load_offset;
        logic  wait_tick;
        logic  begin_conv;
        logic  count_tick;
        logic  sample_bit;
        logic  next_bit;
        logic  end_conv;
        logic  div_avg;
        logic  div_units;
        logic  avg_capture;
        logic  tare_store;
        logic  out_load;
        logic  out_sck;
        logic  out_busy;
        logic  out_done;
        stat_t out_status;
        logic  out_avg;
        logic  out_quot;
    } dp_cmd_t;

    typedef struct packed {
        logic power_down;
        logic scale_zero;
        logic is_tare;
        logic hp_reached;
        logic more_bits;
        logic timeout;
        logic last_sample;
        logic div_busy;
    } dp_sts_t;

endpackage

// ===== rtl/lcar_datapath.sv =====
// Datapath of the load cell reader: config registers, pin counters, accumulator,
// shared serial divider and result register. Depends on lcar_pkg.
`timescale 1ns / 1ps
module lcar_datapath
    import lcar_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_addr,
    input  logic [31:0]          cfg_wdata,
    input  logic                 dout,
    input  logic [7:0]           sample_count,
    input  logic [1:0]           func,
    input  logic [23:0]          offset_value,
    input  dp_cmd_t              cmd,
    output dp_sts_t              sts,
    output logic                 sck,
    output logic                 busy_res,
    output logic                 done_res,
    output logic [1:0]           status,
    output logic [23:0]          raw_average,
    output logic [UNITS_W-1:0]   units_q8
);

    logic [1:0]            gain_reg;
    logic [31:0]           scale_reg;
    logic [7:0]            half_reg;
    logic [31:0]           tmo_reg;
    logic                  pdown_reg;

    logic                  tare_reg;
    logic [4:0]            bit_reg;
    logic [7:0]            tick_reg;
    logic [31:0]           wait_reg;
    logic [31:0]           wait_next;
    logic [DATA_BITS-1:0]  shift_reg;
    logic [COUNT_BITS-1:0] left_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [23:0]           offset_reg;
    logic [23:0]           avg_reg;

    logic [DIVS_W:0]       rem_reg;
    logic [DIVD_W-1:0]     quo_reg;
    logic [DIVS_W-1:0]     dvs_reg;
    logic [DCNT_W-1:0]     dcnt_reg;
    logic                  dbusy_reg;
    logic                  neg_reg;

    logic                  sck_reg, busy_reg, done_reg;
    logic [1:0]            status_reg;
    logic [23:0]           raw_reg;
    logic [UNITS_W-1:0]    units_reg;

    logic [7:0]            hp;
    logic [1:0]            gp;
    logic [COUNT_BITS-1:0] cnt_in;
    logic [DIVS_W:0]       trial;
    logic                  take;
    logic [ACC_W-1:0]      acc_mag;
    logic [24:0]           diff;
    logic [24:0]           diff_mag;
    logic [DIVS_W-1:0]     scale_mag;
    logic [UNITS_W-1:0]    quo_signed;

    always_comb begin
        hp        = (half_reg == 8'd0) ? 8'd1 : half_reg;
        gp        = (gain_reg == 2'd0) ? 2'd1 : gain_reg;
        wait_next = (wait_reg == 32'hFFFF_FFFF) ? wait_reg : wait_reg + 32'd1;
        cnt_in    = (sample_count == 8'd0) ? COUNT_BITS'(1) : COUNT_BITS'(sample_count);
        trial     = {rem_reg[DIVS_W-1:0], quo_reg[DIVD_W-1]};
        take      = trial >= {1'b0, dvs_reg};
        acc_mag   = acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(1)) : acc_reg;
        diff      = {avg_reg[23], avg_reg} - {offset_reg[23], offset_reg};
        diff_mag  = diff[24] ? (~diff + 25'd1) : diff;
        scale_mag = scale_reg[31] ? (~scale_reg + 32'd1) : scale_reg;
        quo_signed = neg_reg ? (~{1'b0, quo_reg} + UNITS_W'(1)) : {1'b0, quo_reg};

        sts.power_down  = pdown_reg;
        sts.scale_zero  = (scale_reg == 32'd0);
        sts.is_tare     = tare_reg;
        sts.hp_reached  = ({1'b0, tick_reg} + 9'd1) >= {1'b0, hp};
        sts.more_bits   = ({1'b0, bit_reg} + 6'd1) < (6'(DATA_BITS) + {4'b0, gp});
        sts.timeout     = (tmo_reg != 32'd0) && (wait_next >= tmo_reg);
        sts.last_sample = left_reg <= COUNT_BITS'(1);
        sts.div_busy    = dbusy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= 2'd1;
            scale_reg <= 32'd256;
            half_reg  <= 8'd1;
            tmo_reg   <= 32'd500000;
            pdown_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_GAIN:    gain_reg  <= cfg_wdata[1:0];
                CFG_SCALE:   scale_reg <= cfg_wdata;
                CFG_HALF:    half_reg  <= cfg_wdata[7:0];
                CFG_TIMEOUT: tmo_reg   <= cfg_wdata;
                CFG_PDOWN:   pdown_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tare_reg   <= 1'b0;
            bit_reg    <= '0;
            tick_reg   <= '0;
            wait_reg   <= '0;
            shift_reg  <= '0;
            left_reg   <= '0;
            total_reg  <= '0;
            acc_reg    <= '0;
            offset_reg <= '0;
            avg_reg    <= '0;
        end else begin
            if (cmd.start) begin
                tare_reg  <= (func == FN_TARE);
                left_reg  <= cnt_in;
                total_reg <= cnt_in;
                acc_reg   <= '0;
                wait_reg  <= '0;
            end
            if (cmd.load_offset) offset_reg <= offset_value;
            if (cmd.tare_store)  offset_reg <= avg_reg;
            if (cmd.wait_tick)   wait_reg   <= wait_next;
            if (cmd.begin_conv) begin
                tick_reg  <= '0;
                bit_reg   <= '0;
                shift_reg <= '0;
            end
            if (cmd.count_tick) tick_reg <= tick_reg + 8'd1;
            if (cmd.sample_bit) begin
                tick_reg <= '0;
                if (bit_reg < 5'(DATA_BITS)) shift_reg <= {shift_reg[DATA_BITS-2:0], dout};
            end
            if (cmd.next_bit) begin
                tick_reg <= '0;
                bit_reg  <= bit_reg + 5'd1;
            end
            if (cmd.end_conv) begin
                tick_reg <= '0;
                wait_reg <= '0;
                acc_reg  <= acc_reg + ACC_W'($signed(shift_reg));
                if (left_reg != '0) left_reg <= left_reg - COUNT_BITS'(1);
            end
            if (cmd.avg_capture) avg_reg <= quo_signed[23:0];
        end
    end

    // Restoring divider on magnitudes, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end else if (cmd.div_avg || cmd.div_units) begin
            dbusy_reg <= 1'b1;
            dcnt_reg  <= DCNT_W'(DIVD_W);
        end else if (dbusy_reg) begin
            dcnt_reg <= dcnt_reg - DCNT_W'(1);
            if (dcnt_reg == DCNT_W'(1)) dbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_avg) begin
            rem_reg <= '0;
            quo_reg <= DIVD_W'(acc_mag);
            dvs_reg <= DIVS_W'(total_reg);
            neg_reg <= acc_reg[ACC_W-1];
        end else if (cmd.div_units) begin
            rem_reg <= '0;
            quo_reg <= {diff_mag, FRAC_SHIFT'(0)};
            dvs_reg <= scale_mag;
            neg_reg <= diff[24] ^ scale_reg[31];
        end else if (dbusy_reg) begin
            rem_reg <= take ? (trial - {1'b0, dvs_reg}) : trial;
            quo_reg <= {quo_reg[DIVD_W-2:0], take};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            sck_reg    <= cmd.out_sck;
            busy_reg   <= cmd.out_busy;
            done_reg   <= cmd.out_done;
            status_reg <= cmd.out_status;
            raw_reg    <= cmd.out_avg ? avg_reg : 24'd0;
            units_reg  <= cmd.out_quot ? quo_signed : '0;
        end
    end

    assign sck         = sck_reg;
    assign busy_res    = busy_reg;
    assign done_res    = done_reg;
    assign status      = status_reg;
    assign raw_average = raw_reg;
    assign units_q8    = units_reg;

endmodule

// ===== rtl/lcar_ctrl.sv =====
// Controller of the load cell reader: tick handshake, pin sequencer phase and
// end-of-request division sequence. Depends on lcar_pkg and the defines header.
`timescale 1ns / 1ps
`include "load_cell_adc_reader_defines.svh"
module lcar_ctrl
    import lcar_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  logic       dout,
    input  logic       req,
    input  logic [1:0] func,
    input  dp_sts_t    sts,
    output dp_cmd_t    cmd
);

    ctrl_t state_reg, state_next;
    pin_t  pin_reg, pin_next;
    logic  clk_reg, clk_next;
    logic  out_valid_reg, out_valid_next;
    logic  out_free;
    logic  accept;
    logic  finish;
    stat_t fin_status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= C_TICK;
            pin_reg       <= PIN_IDLE;
            clk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pin_reg       <= pin_next;
            clk_reg       <= clk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pin_next   = pin_reg;
        clk_next   = clk_reg;
        cmd        = '0;
        finish     = 1'b0;
        fin_status = STAT_OK;
        out_free   = !out_valid_reg || m_tready;
        s_tready   = (state_reg == C_TICK) && out_free;
        accept     = s_tvalid && s_tready;

        unique case (state_reg)
            C_TICK: begin
                if (accept) begin
                    if (sts.power_down) begin
                        clk_next = 1'b1;
                        if (pin_reg != PIN_IDLE || (req && func != FN_NONE)) begin
                            finish     = 1'b1;
                            fin_status = STAT_POWER_DOWN;
                        end
                        pin_next = PIN_IDLE;
                    end else begin
                        unique case (pin_reg)
                            PIN_IDLE: begin
                                clk_next = 1'b0;
                                if (req && func == FN_LOAD) begin
                                    cmd.load_offset = 1'b1;
                                    finish          = 1'b1;
                                end else if (req && (func == FN_READ || func == FN_TARE)) begin
                                    cmd.start = 1'b1;
                                    pin_next  = PIN_WAIT;
                                end
                            end
                            PIN_WAIT: begin
                                if (!dout) begin
                                    cmd.begin_conv = 1'b1;
                                    clk_next       = 1'b1;
                                    pin_next       = PIN_HIGH;
                                end else begin
                                    cmd.wait_tick = 1'b1;
                                    if (sts.timeout) begin
                                        clk_next   = 1'b0;
                                        finish     = 1'b1;
                                        fin_status = STAT_TIMEOUT;
                                        pin_next   = PIN_IDLE;
                                    end
                                end
                            end
                            PIN_HIGH: begin
                                if (sts.hp_reached) begin
                                    cmd.sample_bit = 1'b1;
                                    clk_next       = 1'b0;
                                    pin_next       = PIN_LOW;
                                end else begin
                                    cmd.count_tick = 1'b1;
                                end
                            end
                            PIN_LOW: begin
                                if (!sts.hp_reached) begin
                                    cmd.count_tick = 1'b1;
                                end else if (sts.more_bits) begin
                                    cmd.next_bit = 1'b1;
                                    clk_next     = 1'b1;
                                    pin_next     = PIN_HIGH;
                                end else begin
                                    cmd.end_conv = 1'b1;
                                    if (sts.last_sample) begin
                                        pin_next   = PIN_IDLE;
                                        state_next = C_AVG_GO;
                                    end else begin
                                        pin_next = PIN_WAIT;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                    // every tick but the last conversion's end yields its result now
                    if (state_next == C_TICK) begin
                        cmd.out_load   = 1'b1;
                        cmd.out_sck    = clk_next;
                        cmd.out_busy   = (pin_next != PIN_IDLE);
                        cmd.out_done   = finish;
                        cmd.out_status = fin_status;
                    end
                end
            end
            C_AVG_GO: begin
                cmd.div_avg = 1'b1;
                state_next  = C_AVG;
            end
            C_AVG: begin
                if (!sts.div_busy) begin
                    cmd.avg_capture = 1'b1;
                    state_next      = C_POST;
                end
            end
            C_POST: begin
                if (!sts.is_tare && !sts.scale_zero) begin
                    cmd.div_units = 1'b1;
                    state_next    = C_UNITS;
                end else if (out_free) begin
                    cmd.tare_store = sts.is_tare;
                    cmd.out_load   = 1'b1;
                    cmd.out_sck    = clk_reg;
                    cmd.out_done   = 1'b1;
                    cmd.out_avg    = 1'b1;
                    cmd.out_status = sts.is_tare ? STAT_OK : STAT_ZERO_SCALE;
                    state_next     = C_TICK;
                end
            end
            C_UNITS: begin
                if (!sts.div_busy && out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sck    = clk_reg;
                    cmd.out_done   = 1'b1;
                    cmd.out_avg    = 1'b1;
                    cmd.out_quot   = 1'b1;
                    cmd.out_status = STAT_OK;
                    state_next     = C_TICK;
                end
            end
            default: state_next = C_TICK;
        endcase

        if (cmd.out_load)      out_valid_next = 1'b1;
        else if (m_tready)     out_valid_next = 1'b0;
        else                   out_valid_next = out_valid_reg;
        m_tvalid = out_valid_reg;
    end

    `LCAR_ASSERT_NOW(a_load_into_free, cmd.out_load, !out_valid_reg || m_tready)
    `LCAR_ASSERT_NOW(a_pins_idle_in_div, state_reg != C_TICK, pin_reg == PIN_IDLE)
    `LCAR_ASSERT_NEXT(a_div_starts, cmd.div_avg || cmd.div_units, sts.div_busy)
    `LCAR_ASSERT_NOW(a_no_take_in_div, state_reg != C_TICK, !s_tready)

endmodule

// ===== rtl/load_cell_adc_reader.sv =====
// Load cell reader: one input transfer per timing tick, one result transfer per tick.
// The result of an ordinary tick is registered and shows the next cycle.
// The tick ending the last conversion of a read runs two serial divisions on the shared
// divider, a tare or a zero-scale read one. aresetn is synchronous, active low: config
// returns to defaults, sequencer idles.
`timescale 1ns / 1ps
module load_cell_adc_reader
    import lcar_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // dout, req, sample_count[7:0], offset_value[23:0]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // sck, busy_res, done_res, status[1:0],
                                   // raw_average[23:0], units_q8[41:0]
);

    dp_cmd_t            cmd;
    dp_sts_t            sts;
    logic               sck, busy_res, done_res;
    logic [1:0]         status;
    logic [23:0]        raw_average;
    logic [UNITS_W-1:0] units_q8;

    lcar_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dout     (s_tdata[0]),
        .req      (s_tdata[1]),
        .func     (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    lcar_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .dout         (s_tdata[0]),
        .sample_count (s_tdata[9:2]),
        .func         (s_tuser),
        .offset_value (s_tdata[33:10]),
        .cmd          (cmd),
        .sts          (sts),
        .sck          (sck),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .status       (status),
        .raw_average  (raw_average),
        .units_q8     (units_q8)
    );

    assign m_tdata = {1'b0, units_q8, raw_average, status, done_res, busy_res, sck};

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for load_cell_adc_reader: random ticks and requests, per-tick prediction.
// Depends on lcar_pkg and the load_cell_adc_reader RTL only.
`timescale 1ns / 1ps
module tb;
    import lcar_pkg::*;

    class reader_scoreboard;
        // configuration copy
        logic [1:0]  gain;
        longint      scale;
        logic [7:0]  half;
        int unsigned timeout;
        bit          pdown;
        // sequencer copy
        pin_t        ph;
        logic [1:0]  kind;
        int unsigned bit_idx, ticks, waitc, left, total;
        logic [23:0] shift;
        longint      acc, zoff;
        bit          clk_lvl;
        logic [71:0] tick_q[$];
        logic [71:0] cur;
        int          errors;

        function void reset_all();
            gain = 2'd1; scale = 256; half = 8'd1; timeout = 500000; pdown = 0;
            ph = PIN_IDLE; kind = FN_READ; bit_idx = 0; ticks = 0; waitc = 0;
            left = 0; total = 0; shift = '0; acc = 0; zoff = 0; clk_lvl = 0;
            errors = 0;
            tick_q.delete();
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                CFG_GAIN:    gain = val[1:0];
                CFG_SCALE:   scale = longint'(signed'(val));
                CFG_HALF:    half = val[7:0];
                CFG_TIMEOUT: timeout = val;
                CFG_PDOWN:   pdown = val[0];
                default: ;
            endcase
        endfunction

        function longint clamp(longint v, int w);
            longint hi, lo;
            hi = (longint'(1) <<< (w - 1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function void close_req(stat_t st, longint avg, longint units);
            logic [23:0] a;
            logic [41:0] u;
            a = avg[23:0];
            u = units[41:0];
            ph = PIN_IDLE;
            cur[2] = 1'b1;
            cur[4:3] = st;
            cur[28:5] = a;
            cur[70:29] = u;
        endfunction

        function void average_out();
            longint avg, diff;
            avg = acc / longint'(total == 0 ? 1 : total);
            if (kind == FN_TARE) begin
                zoff = clamp(avg, 24);
                close_req(STAT_OK, avg, 0);
            end else if (scale == 0) begin
                close_req(STAT_ZERO_SCALE, avg, 0);
            end else begin
                diff = avg - zoff;
                close_req(STAT_OK, avg, clamp((diff * 65536) / scale, 42));
            end
        endfunction

        // advance one tick and queue the result it causes
        function void note(bit dout, bit req, logic [1:0] fn, logic [7:0] cnt,
                           logic [23:0] offv);
            int unsigned hp, gp;
            hp = (half == 0) ? 1 : half;
            gp = (gain == 0) ? 1 : gain;
            cur = '0;
            if (pdown) begin
                clk_lvl = 1;
                if (ph != PIN_IDLE || (req && fn != FN_NONE))
                    close_req(STAT_POWER_DOWN, 0, 0);
                ph = PIN_IDLE;
            end else begin
                case (ph)
                    PIN_IDLE: begin
                        clk_lvl = 0;
                        if (req && fn == FN_LOAD) begin
                            zoff = longint'(signed'(offv));
                            close_req(STAT_OK, 0, 0);
                        end else if (req && (fn == FN_READ || fn == FN_TARE)) begin
                            kind = fn;
                            left = (cnt == 0) ? 1 : cnt;
                            total = left;
                            acc = 0;
                            waitc = 0;
                            ph = PIN_WAIT;
                        end
                    end
                    PIN_WAIT: begin
                        if (!dout) begin
                            ph = PIN_HIGH; clk_lvl = 1; ticks = 0; bit_idx = 0; shift = '0;
                        end else begin
                            if (waitc != 32'hFFFF_FFFF) waitc++;
                            if (timeout != 0 && waitc >= timeout) begin
                                clk_lvl = 0;
                                close_req(STAT_TIMEOUT, 0, 0);
                            end
                        end
                    end
                    PIN_HIGH: begin
                        ticks++;
                        if (ticks >= hp) begin
                            if (bit_idx < DATA_BITS) shift = {shift[22:0], dout};
                            clk_lvl = 0; ticks = 0; ph = PIN_LOW;
                        end
                    end
                    default: begin
                        ticks++;
                        if (ticks >= hp) begin
                            ticks = 0;
                            bit_idx++;
                            if (bit_idx < DATA_BITS + gp) begin
                                clk_lvl = 1; ph = PIN_HIGH;
                            end else begin
                                acc += longint'(signed'(shift));
                                if (left != 0) left--;
                                if (left == 0) average_out();
                                else begin
                                    waitc = 0; ph = PIN_WAIT;
                                end
                            end
                        end
                    end
                endcase
            end
            cur[0] = clk_lvl;
            cur[1] = (ph != PIN_IDLE);
            tick_q.push_back(cur);
        endfunction

        task report(string what, logic [71:0] got, logic [71:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check(logic [71:0] got);
            logic [71:0] want;
            if (tick_q.size() == 0) begin
                report("unexpected transfer", got, '0);
                return;
            end
            want = tick_q.pop_front();
            if (got[0] != want[0])         report("sck", got, want);
            if (got[1] != want[1])         report("busy_res", got, want);
            if (got[2] != want[2])         report("done_res", got, want);
            if (got[4:3] != want[4:3])     report("status", got, want);
            if (got[28:5] != want[28:5])   report("raw_average", got, want);
            if (got[70:29] != want[70:29]) report("units_q8", got, want);
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [71:0] m_tdata;

    reader_scoreboard sb;
    int  n_ticks;
    int  n_results;
    bit  tx_burst, rx_burst;

    typedef struct {
        logic [1:0]  gain;
        logic [31:0] scale;
        logic [7:0]  half;
        logic [31:0] timeout;
        bit          pdown;
        int          budget;
        bit          force_to;
    } setting_t;

    setting_t plan[8];

    load_cell_adc_reader i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    task send_tick(bit dout, bit req, logic [1:0] fn, logic [7:0] cnt, logic [23:0] offv);
        int gap;
        if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, offv, cnt, req, dout};
        s_tuser  <= fn;
        do @(posedge aclk); while (!s_tready);
        sb.note(dout, req, fn, cnt, offv);
        n_ticks++;
    endtask

    // hold the write enable; the caller drops it after the last write
    task write_cfg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (sb.tick_q.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        if (guard >= 200000) begin
            $display("status: fail");
            $finish;
        end
        // cover the division tail of the last tick
        repeat (120) @(posedge aclk);
    endtask

    // issue a request and keep ticking until the sequencer returns to idle
    task run_request(logic [1:0] fn, logic [7:0] cnt, logic [23:0] offv, bit hold_high);
        bit d;
        send_tick($urandom_range(0, 1), 1'b1, fn, cnt, offv);
        while (sb.ph != PIN_IDLE) begin
            if (sb.ph == PIN_WAIT) d = hold_high ? 1'b1 : ($urandom_range(0, 2) != 0);
            else d = $urandom_range(0, 1);
            send_tick(d, $urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 255),
                      $urandom());
        end
    endtask

    // receive side, with one long hold-off to back the block up
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 15);
            if (n_results == 150) gap = 400;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check(m_tdata);
            n_results++;
        end
    end

    initial begin
        int  base;
        bit  hh;
        logic [1:0] fn;
        sb = new();
        sb.reset_all();
        n_ticks = 0;
        n_results = 0;
        plan[0] = '{2'd1, 32'd256,        8'd1,   32'd500000, 0, 100, 0};
        plan[1] = '{2'd3, 32'hFFFF_FFFF,  8'd2,   32'd6,      0, 100, 0};
        plan[2] = '{2'd2, 32'h7FFF_FFFF,  8'd1,   32'd0,      0, 100, 0};
        plan[3] = '{2'd1, 32'd0,          8'd1,   32'd40,     0, 80,  0};
        plan[4] = '{2'd0, 32'h8000_0000,  8'd0,   32'hFFFF_FFFF, 0, 100, 0};
        plan[5] = '{2'd2, 32'd300,        8'd255, 32'd4,      0, 30,  1};
        plan[6] = '{2'd1, 32'd256,        8'd1,   32'd500000, 1, 100, 0};
        plan[7] = '{2'd1, -32'sd5000,     8'd3,   32'd50,     0, 90,  0};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed opening at reset settings
        run_request(FN_LOAD, 8'd0, 24'h800000, 0);
        run_request(FN_LOAD, 8'd255, 24'h7FFFFF, 0);
        run_request(FN_NONE, 8'd1, 24'h0, 0);
        run_request(FN_READ, 8'd0, 24'h0, 0);
        run_request(FN_TARE, 8'd1, 24'h0, 0);
        run_request(FN_READ, 8'd2, 24'h0, 0);
        run_request(FN_LOAD, 8'd0, 24'h000000, 0);

        for (int p = 0; p < 8; p++) begin
            drain();
            write_cfg(CFG_GAIN, {30'd0, plan[p].gain});
            write_cfg(CFG_SCALE, plan[p].scale);
            write_cfg(CFG_HALF, {24'd0, plan[p].half});
            write_cfg(CFG_TIMEOUT, plan[p].timeout);
            write_cfg(CFG_PDOWN, {31'd0, plan[p].pdown});
            cfg_we <= 1'b0;
            base = n_ticks;
            while (n_ticks - base < plan[p].budget) begin
                hh = plan[p].force_to ||
                     (plan[p].timeout != 0 && plan[p].timeout < 1000 &&
                      $urandom_range(0, 3) == 0);
                case ($urandom_range(0, 9))
                    0: send_tick($urandom_range(0, 1), 1'b0, $urandom_range(0, 3),
                                 $urandom_range(0, 255), $urandom());
                    1: run_request(FN_LOAD, $urandom_range(0, 255), $urandom(), 0);
                    2: run_request(FN_NONE, $urandom_range(0, 255), $urandom(), 0);
                    default: begin
                        fn = $urandom_range(0, 1);
                        run_request(fn, $urandom_range(0, 3), $urandom(), hh);
                    end
                endcase
            end
        end
        drain();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/lcar_pkg.sv
rtl/lcar_datapath.sv
rtl/lcar_ctrl.sv
rtl/load_cell_adc_reader.sv
tb/tb.sv
